[hw/rtl/fpba_pkg.sv]
package fpba_pkg;

    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int FIELD_SIZE_W  = 16;
    localparam int FIELD_INDEX_W = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd1;

    localparam int BLOCK_COUNT_W = 5;
    localparam int FIT_MODE_W    = 2;

    localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RESET = 5'd16;

    localparam logic [FIT_MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [FIT_MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [FIT_MODE_W-1:0] FIT_WORST = 2'd2;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [FIELD_INDEX_W-1:0] block_index;
        logic [FIELD_SIZE_W-1:0]  block_size;
        logic [FIELD_SIZE_W-1:0]  request_size;
    } in_item_t;

    typedef struct packed {
        logic                     granted;
        logic [FIELD_INDEX_W-1:0] chosen_block;
    } out_item_t;

endpackage

[hw/rtl/fpba_ram.sv]
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/fpba_ctrl.sv]
module fpba_ctrl #(
    parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  fpba_pkg::in_item_t                 in_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output fpba_pkg::out_item_t                out_item,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]    blk_count,
    input  logic [fpba_pkg::FIT_MODE_W-1:0]    fit_mode
);
    import fpba_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = $clog2(MAX_BLOCKS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN,
        S_EMIT
    } state_t;

    state_t                  state_reg,    state_next;
    logic [SIZE_BITS-1:0]    req_reg,      req_next;
    logic [FIT_MODE_W-1:0]   mode_reg,     mode_next;
    logic [CNT_W-1:0]        cnt_reg,      cnt_next;
    logic [CNT_W-1:0]        issue_reg,    issue_next;
    logic                    rd_pend_reg,  rd_pend_next;
    logic [IDX_W-1:0]        rd_idx_reg,   rd_idx_next;
    logic                    rd_vld_reg,   rd_vld_next;
    logic                    found_reg,    found_next;
    logic [IDX_W-1:0]        pick_reg,     pick_next;
    logic [SIZE_BITS-1:0]    best_reg,     best_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_item_reg, out_item_next;
    logic [MAX_BLOCKS-1:0]   vld_reg,      vld_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [SIZE_BITS-1:0]    ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [SIZE_BITS-1:0]    ram_rdata;

    logic                    in_xfer;
    logic [SIZE_BITS-1:0]    cand;
    logic                    fits;
    logic                    better;
    logic                    take;
    logic [CNT_W-1:0]        issue_inc;

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign ram_raddr = issue_reg[IDX_W-1:0];
    assign issue_inc = issue_reg + CNT_W'(1);

    // shared compare unit
    always_comb
    begin
        cand   = rd_vld_reg ? ram_rdata : '0;
        fits   = (cand >= req_reg);
        better = !found_reg
              || ((mode_reg == FIT_BEST)  && (cand < best_reg))
              || ((mode_reg == FIT_WORST) && (cand > best_reg));
        take   = rd_pend_reg && fits && better;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        issue_next     = issue_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = ram_raddr;
        rd_vld_next    = vld_reg[ram_raddr];
        found_next     = found_reg;
        pick_next      = pick_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        vld_next       = vld_reg;
        ram_we         = 1'b0;
        ram_waddr      = pick_reg;
        ram_wdata      = best_reg - req_reg;

        if (take)
        begin
            found_next = 1'b1;
            pick_next  = rd_idx_reg;
            best_next  = cand;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_item.action == ACT_LOAD)
                    begin
                        if (32'(in_item.block_index) < MAX_BLOCKS)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = IDX_W'(in_item.block_index);
                            ram_wdata = SIZE_BITS'(in_item.block_size);
                        end
                    end
                    else
                    begin
                        req_next   = SIZE_BITS'(in_item.request_size);
                        mode_next  = fit_mode;
                        cnt_next   = blk_count;
                        issue_next = '0;
                        found_next = 1'b0;
                        state_next = (blk_count == '0) ? S_FIN : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rd_pend_next = 1'b1;
                issue_next   = issue_inc;
                if (issue_inc == cnt_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                ram_we     = found_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.granted      = found_reg;
                    out_item_next.chosen_block = found_reg
                                               ? FIELD_INDEX_W'(pick_reg) : '0;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ram_we)
        begin
            vld_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
            vld_reg       <= '0;
            issue_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
            vld_reg       <= vld_next;
            issue_reg     <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        mode_reg     <= mode_next;
        cnt_reg      <= cnt_next;
        rd_idx_reg   <= rd_idx_next;
        rd_vld_reg   <= rd_vld_next;
        pick_reg     <= pick_next;
        best_reg     <= best_next;
    end

    a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg && (state_reg != S_IDLE)) |-> (best_reg >= req_reg))
        else $error("held pick smaller than request");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_reg < cnt_reg))
        else $error("scan address beyond block count");

    a_pick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && found_reg) |-> (32'(pick_reg) < 32'(cnt_reg)))
        else $error("pick outside searched blocks");

    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_item.action == ACT_REQUEST) |=> in_stall)
        else $error("request transfer did not start a scan");

    a_drain_compare: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> rd_pend_reg)
        else $error("last read missing at drain");

endmodule

[hw/rtl/fit_policy_block_allocator.sv]
// Channel  | Direction | Handshake            | Payload
// in       | input     | in_valid / in_stall  | in_item  (action, index, sizes)
// out      | output    | out_valid / out_stall| out_item (granted, chosen_block)
// cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A load writes the table on the transfer edge.
// A request scans the clamped block count: one read of the size memory per
// block through a single compare unit, then update and result. With a count
// of zero the scan is skipped.
// A result waits in the output register while out_stall is high; a new item is
// taken meanwhile, and the next request holds its result until that one leaves.
// Reset clears the per-block valid bits at once, so every size reads as zero.
module fit_policy_block_allocator #(
    parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  fpba_pkg::in_item_t              in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output fpba_pkg::out_item_t             out_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fpba_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [BLOCK_COUNT_W-1:0] block_count_reg;
    logic [FIT_MODE_W-1:0]    fit_mode_reg;
    logic [CNT_W-1:0]         count_clamped;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_RESET;
            fit_mode_reg    <= FIT_FIRST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BLOCK_COUNT: block_count_reg <= cfg_data[BLOCK_COUNT_W-1:0];
                CFG_FIT_MODE:    fit_mode_reg    <= cfg_data[FIT_MODE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (32'(block_count_reg) > MAX_BLOCKS)
        begin
            count_clamped = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            count_clamped = CNT_W'(block_count_reg);
        end
    end

    fpba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .blk_count (count_clamped),
        .fit_mode  (fit_mode_reg)
    );

endmodule
